// ===== sv/bfba_pkg.sv =====
`timescale 1ns / 1ps
package bfba_pkg;

  localparam int FREE_ENTRIES = 16;
  localparam int IDX_W = $clog2(FREE_ENTRIES);
  localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
  localparam int DATA_W = 32;
  localparam int STEP_W = $clog2(DATA_W);
  localparam int CHUNK_W = 17;
  localparam int PID_W = 16;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(256);

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_ALLOC  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_BAD_PID    = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_SCAN,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [DATA_W-1:0] need;
  } rnd_res_t;

endpackage

// ===== sv/bfba_round.sv =====
`timescale 1ns / 1ps
module bfba_round
  import bfba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [DATA_W-1:0]  size_in,
  input  logic [CHUNK_W-1:0] chunk,
  output rnd_res_t           res
);

  logic               busy;
  logic               fin;
  logic               done;
  logic               ovf;
  logic [DATA_W-1:0]  need;
  logic [STEP_W-1:0]  cnt;
  logic [CHUNK_W-1:0] g;
  logic [CHUNK_W-1:0] r;
  logic [CHUNK_W-1:0] r_next;
  logic [DATA_W-1:0]  sh;
  logic [DATA_W-1:0]  sz;
  logic [CHUNK_W:0]   t;
  logic [DATA_W:0]    sum;

  assign res = {done, ovf, need};

  // one quotient bit per cycle, remainder only
  always_comb begin
    t = {r, sh[DATA_W-1]};
    if (t >= {1'b0, g}) begin
      r_next = CHUNK_W'(t - {1'b0, g});
    end else begin
      r_next = t[CHUNK_W-1:0];
    end
    if (r != '0) begin
      sum = {1'b0, sz} + (DATA_W+1)'(g - r);
    end else begin
      sum = {1'b0, sz};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        fin  <= 1'b0;
      end else if (busy) begin
        if (cnt == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt <= '0;
      r   <= '0;
      sh  <= size_in;
      sz  <= size_in;
      g   <= (chunk == '0) ? CHUNK_W'(1) : chunk;
    end else if (busy) begin
      cnt <= cnt + STEP_W'(1);
      r   <= r_next;
      sh  <= {sh[DATA_W-2:0], 1'b0};
    end else if (fin) begin
      need <= sum[DATA_W-1:0];
      ovf  <= sum[DATA_W];
    end
  end

endmodule

// ===== sv/bfba_mem.sv =====
`timescale 1ns / 1ps
module bfba_mem
  import bfba_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [FREE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/best_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// Best-fit free-block allocator.
// Input channel (in_valid/in_ready): cmd, process_id, req_size, block_start.
//   cmd 0 appends a free block to the table; cmd 1 allocates req_size bytes,
//   rounded up to a multiple of chunk_size, from the smallest block that fits.
// Output channel (out_valid/out_ready): address and status, one item per input.
// Config channel (cfg_valid/cfg_ready): writes chunk_size; write it while idle.
// One item at a time; in_ready is high only while no item is in work.
// Steps: an append or a bad pid goes straight to the result; an allocation
//   first finds the rounded size with the one-bit-per-cycle remainder (an
//   overflow ends it with no fit), then scans the table entries through the
//   single read port, then on an exact fit moves each later entry down by one.
// in_ready returns on the same edge that raises out_valid.
// The result register frees the input side: a new item is taken while a
//   result still waits; a stalled receiver only holds the following result.
// Reset: table empty, chunk_size 256, no result pending.
module best_fit_block_allocator_unit
  import bfba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [PID_W-1:0]   process_id,
  input  logic [DATA_W-1:0]  req_size,
  input  logic [DATA_W-1:0]  block_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  address,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CHUNK_W-1:0] chunk_size
);

  state_t             state;
  state_t             state_next;
  logic [CHUNK_W-1:0] chunk;
  logic [CNT_W-1:0]   free_count;
  logic [CNT_W-1:0]   free_count_next;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   idx_next;
  logic               pv;
  logic               pv_next;
  logic [IDX_W-1:0]   pidx;
  logic               found;
  logic               found_next;
  logic [IDX_W-1:0]   best;
  logic [IDX_W-1:0]   best_next;
  logic [DATA_W-1:0]  best_size;
  logic [DATA_W-1:0]  best_size_next;
  logic [DATA_W-1:0]  best_start;
  logic [DATA_W-1:0]  best_start_next;
  logic [DATA_W-1:0]  need;
  logic [DATA_W-1:0]  need_next;
  logic [DATA_W-1:0]  res_addr;
  logic [DATA_W-1:0]  res_addr_next;
  status_t            res_st;
  status_t            res_st_next;
  logic               load_out;
  logic               accept;
  logic               rnd_go;
  rnd_res_t           rnd;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  entry_t             rdata;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign rnd_go    = accept && (cmd == CMD_ALLOC) && (process_id != '0);

  bfba_round u_round (
    .clk     (clk),
    .rst     (rst),
    .go      (rnd_go),
    .size_in (req_size),
    .chunk   (chunk),
    .res     (rnd)
  );

  bfba_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next      = state;
    free_count_next = free_count;
    idx_next        = idx;
    pv_next         = 1'b0;
    found_next      = found;
    best_next       = best;
    best_size_next  = best_size;
    best_start_next = best_start;
    need_next       = need;
    res_addr_next   = res_addr;
    res_st_next     = res_st;
    load_out        = 1'b0;
    we              = 1'b0;
    waddr           = idx[IDX_W-1:0];
    wdata           = rdata;
    re              = 1'b0;
    raddr           = idx[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_addr_next = '0;
          if (cmd == CMD_APPEND) begin
            if (free_count == CNT_W'(FREE_ENTRIES)) begin
              res_st_next = ST_TABLE_FULL;
            end else begin
              we              = 1'b1;
              waddr           = free_count[IDX_W-1:0];
              wdata.start     = block_start;
              wdata.size      = req_size;
              free_count_next = free_count + CNT_W'(1);
              res_st_next     = ST_OK;
            end
            state_next = S_DONE;
          end else if (process_id == '0) begin
            res_st_next = ST_BAD_PID;
            state_next  = S_DONE;
          end else begin
            state_next = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        if (rnd.done) begin
          if (rnd.ovf) begin
            res_st_next = ST_NO_FIT;
            state_next  = S_DONE;
          end else begin
            need_next  = rnd.need;
            idx_next   = '0;
            found_next = 1'b0;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx < free_count) begin
          re       = 1'b1;
          idx_next = idx + CNT_W'(1);
          pv_next  = 1'b1;
        end
        if (pv && (rdata.size >= need) && (!found || (rdata.size < best_size))) begin
          found_next      = 1'b1;
          best_next       = pidx;
          best_size_next  = rdata.size;
          best_start_next = rdata.start;
        end
        if (!pv && (idx == free_count)) begin
          if (!found) begin
            res_st_next = ST_NO_FIT;
            state_next  = S_DONE;
          end else begin
            res_st_next   = ST_OK;
            res_addr_next = best_start;
            if (best_size == need) begin
              idx_next   = CNT_W'(best);
              state_next = S_SH_RD;
            end else begin
              we          = 1'b1;
              waddr       = best;
              wdata.start = best_start + need;
              wdata.size  = best_size - need;
              state_next  = S_DONE;
            end
          end
        end
      end
      S_SH_RD: begin
        if ((idx + CNT_W'(1)) < free_count) begin
          re         = 1'b1;
          raddr      = IDX_W'(idx + CNT_W'(1));
          state_next = S_SH_WR;
        end else begin
          free_count_next = free_count - CNT_W'(1);
          state_next      = S_DONE;
        end
      end
      S_SH_WR: begin
        we         = 1'b1;
        idx_next   = idx + CNT_W'(1);
        state_next = S_SH_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      chunk      <= CHUNK_RESET;
      out_valid  <= 1'b0;
      pv         <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      pv         <= pv_next;
      if (cfg_valid && cfg_ready) begin
        chunk <= chunk_size;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pidx       <= idx[IDX_W-1:0];
    found      <= found_next;
    best       <= best_next;
    best_size  <= best_size_next;
    best_start <= best_start_next;
    need       <= need_next;
    res_addr   <= res_addr_next;
    res_st     <= res_st_next;
    if (load_out) begin
      address <= res_addr;
      status  <= res_st;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(FREE_ENTRIES))
    else $error("free block count above table depth");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_APPEND) && (free_count == CNT_W'(FREE_ENTRIES))
    |=> free_count == CNT_W'(FREE_ENTRIES))
    else $error("append to full table changed count");

  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && found |-> best_size >= need)
    else $error("chosen block smaller than request");

  a_err_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> address == '0)
    else $error("nonzero address on failed item");
`endif

endmodule

// ===== bench/tb_best_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
module tb_best_fit_block_allocator_unit
  import bfba_pkg::*;
();

  localparam int LIMIT = 800000;
  localparam int PHASE_ITEMS = 55;

  typedef struct {
    cmd_t              cmd;
    logic [PID_W-1:0]  pid;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] start;
  } table_op_t;

  typedef struct {
    logic [DATA_W-1:0] address;
    status_t           status;
  } table_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = 1'b0;
  logic [PID_W-1:0]   process_id = '0;
  logic [DATA_W-1:0]  req_size = '0;
  logic [DATA_W-1:0]  block_start = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DATA_W-1:0]  address;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CHUNK_W-1:0] chunk_size = CHUNK_RESET;

  best_fit_block_allocator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .process_id  (process_id),
    .req_size    (req_size),
    .block_start (block_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .address     (address),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .chunk_size  (chunk_size)
  );

  // free-block table as the block should hold it
  logic [DATA_W-1:0]  fs_start [FREE_ENTRIES];
  logic [DATA_W-1:0]  fs_size  [FREE_ENTRIES];
  int                 fs_count = 0;
  logic [CHUNK_W-1:0] granule_reg = CHUNK_RESET;

  table_op_t    pending_ops[$];
  table_reply_t reply_q[$];
  table_op_t    cur_op;
  int           ops_queued = 0;
  int           ops_taken = 0;
  int           fails = 0;
  int           cycles = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  bit           tx_idle_on = 1'b1;
  int           rx_mode = 1;
  logic [15:0]  stall_pat = 16'hA5C3;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t r;
    logic [63:0]  g;
    logic [63:0]  need;
    int           best;
    r.address = '0;
    r.status = ST_OK;
    if (op.cmd == CMD_APPEND) begin
      if (fs_count >= FREE_ENTRIES) begin
        r.status = ST_TABLE_FULL;
      end else begin
        fs_start[fs_count] = op.start;
        fs_size[fs_count] = op.size;
        fs_count++;
      end
    end else if (op.pid == 0) begin
      r.status = ST_BAD_PID;
    end else begin
      g = (granule_reg == 0) ? 64'd1 : 64'(granule_reg);
      need = ((64'(op.size) + g - 64'd1) / g) * g;
      best = -1;
      if (need <= 64'hFFFF_FFFF) begin
        for (int i = 0; i < fs_count; i++) begin
          if (fs_size[i] >= need[31:0] && (best < 0 || fs_size[i] < fs_size[best])) best = i;
        end
      end
      if (best < 0) begin
        r.status = ST_NO_FIT;
      end else begin
        r.address = fs_start[best];
        if (fs_size[best] == need[31:0]) begin
          for (int i = best; i < fs_count - 1; i++) begin
            fs_start[i] = fs_start[i + 1];
            fs_size[i] = fs_size[i + 1];
          end
          fs_count--;
        end else begin
          fs_size[best] -= need[31:0];
          fs_start[best] += need[31:0];
        end
      end
    end
    return r;
  endfunction

  function automatic table_op_t op_of(cmd_t c, int pid, logic [31:0] sz, logic [31:0] st);
    table_op_t op;
    op.cmd = c;
    op.pid = pid[PID_W-1:0];
    op.size = sz;
    op.start = st;
    return op;
  endfunction

  // steer toward fits and exact fits using the current table contents
  function automatic table_op_t next_table_op();
    table_op_t   op;
    logic [31:0] g;
    logic [31:0] base;
    int          idx;
    int          append_pct;
    g = (granule_reg == 0) ? 32'd1 : 32'(granule_reg);
    op.pid = PID_W'($urandom_range(1, 16'hFFFF));
    op.start = $urandom;
    op.size = '0;
    append_pct = (fs_count < 4) ? 70 : (fs_count >= 14) ? 15 : 40;
    if ($urandom_range(0, 99) < append_pct) begin
      op.cmd = CMD_APPEND;
      if ($urandom_range(0, 9) == 0) op.pid = '0;
      if ($urandom_range(0, 7) == 0) op.start = 32'hFFFF_FFFF - $urandom_range(0, 4 * g);
      case ($urandom_range(0, 9))
        0: op.size = $urandom;
        1: op.size = '0;
        2: op.size = $urandom_range(1, 4096);
        default: op.size = g * $urandom_range(1, 12);
      endcase
    end else begin
      op.cmd = CMD_ALLOC;
      if ($urandom_range(0, 19) == 0) op.pid = '0;
      idx = (fs_count > 0) ? $urandom_range(0, fs_count - 1) : 0;
      base = (fs_count > 0) ? fs_size[idx] : 32'd0;
      case ($urandom_range(0, 11))
        0: op.size = $urandom;
        1: op.size = '0;
        2: op.size = 32'hFFFF_FFFF - $urandom_range(0, 3);
        3: op.size = $urandom_range(1, 2 * g);
        4, 5, 6: op.size = base;
        7, 8: op.size = (base > g) ? base - $urandom_range(0, g - 1) : base;
        default: op.size = g * $urandom_range(1, 4);
      endcase
    end
    return op;
  endfunction

  task automatic queue_op(table_op_t op);
    pending_ops.insert(pending_ops.size(), op);
    ops_queued++;
  endtask

  task automatic wait_drain();
    while (ops_taken != ops_queued || reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_granule(logic [CHUNK_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    chunk_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    granule_reg = v;
  endtask

  // input side: bursts and gaps
  always @(posedge clk) begin : drive_ops
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        reply_q.insert(reply_q.size(), apply_table_op(cur_op));
        ops_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          cmd <= cur_op.cmd;
          process_id <= cur_op.pid;
          req_size <= cur_op.size;
          block_start <= cur_op.start;
          busy = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            if (tx_idle_on)
              gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= busy;
    end
  end

  // result side: check and stall
  always @(posedge clk) begin : check_replies
    table_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected item: address %h status %0d", $time, address, status);
          fails++;
        end else begin
          want = reply_q.pop_front();
          if (address !== want.address) begin
            $display("%0t: address mismatch: expected %h, actual %h",
                     $time, want.address, address);
            fails++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
            fails++;
          end
        end
      end
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= stall_pat[0];
        default: out_ready <= stall_pat[0] & 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_best_fit_block_allocator_unit: FAIL");
      $finish;
    end
  end

  initial begin
    logic [CHUNK_W-1:0] plan [10];
    logic [CHUNK_W-1:0] v;
    plan = '{17'd1, 17'd0, 17'h1FFFF, 17'd65536, 17'd65537, 17'd3, 17'd4096, 17'd0,
             17'd7, 17'd256};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, bad pid, ties, wrap, zero sizes, full table, long shift
    queue_op(op_of(CMD_ALLOC, 1, 32'd0, 32'd0));
    queue_op(op_of(CMD_ALLOC, 0, 32'd100, 32'd0));
    queue_op(op_of(CMD_APPEND, 0, 32'h400, 32'h1000));
    queue_op(op_of(CMD_APPEND, 7, 32'h300, 32'hFFFF_FF00));
    queue_op(op_of(CMD_APPEND, 8, 32'h0, 32'h0));
    queue_op(op_of(CMD_APPEND, 9, 32'h400, 32'h2000));
    queue_op(op_of(CMD_ALLOC, 16'hFFFF, 32'd0, 32'hFFFF_FFFF));
    queue_op(op_of(CMD_ALLOC, 1, 32'h1FF, 32'd0));
    queue_op(op_of(CMD_ALLOC, 2, 32'h101, 32'd0));
    queue_op(op_of(CMD_ALLOC, 3, 32'hFFFF_FFFF, 32'd0));
    queue_op(op_of(CMD_ALLOC, 4, 32'h100, 32'd0));
    for (int i = 0; i < 14; i++) begin
      queue_op(op_of(CMD_APPEND, i, (i == 5) ? 32'hFFFF_FFFF : 32'h100 * (i + 1),
                     (i == 3) ? 32'hFFFF_FFFF : 32'h10000 * i));
    end
    queue_op(op_of(CMD_APPEND, 5, 32'h800, 32'h5000));
    queue_op(op_of(CMD_ALLOC, 5, 32'h300, 32'd0));
    wait_drain();

    for (int ph = 0; ph < 10; ph++) begin
      v = (ph == 9) ? 17'($urandom_range(2, 131071)) : plan[ph];
      write_granule(v);
      tx_idle_on = (ph % 3 != 1);
      rx_mode = ph % 3;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (pending_ops.size() >= 2) @(posedge clk);
        queue_op(next_table_op());
      end
      wait_drain();
    end

    repeat (100) @(posedge clk);
    if (fails == 0)
      $display("tb_best_fit_block_allocator_unit: PASS");
    else
      $display("tb_best_fit_block_allocator_unit: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bfba_pkg.sv
sv/bfba_round.sv
sv/bfba_mem.sv
sv/best_fit_block_allocator_unit.sv
bench/tb_best_fit_block_allocator_unit.sv
